// ===== sv/shbe_pkg.sv =====
// package: shared types, constants and arithmetic helpers of the sh basis evaluator
`timescale 1ns / 1ps
`default_nettype none
package shbe_pkg;

  localparam int unsigned MaxBandLimit = 4;
  localparam int unsigned FracBits     = 14;
  localparam int unsigned NumCoeff     = 25;
  localparam int unsigned BandW        = 3;
  localparam int unsigned IdxW         = 5;
  localparam logic [BandW-1:0] MaxBandReset = 3'd2;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } shbe_in_t;

  typedef struct packed {
    logic [2:0]         band_l;
    logic signed [3:0]  order_m;
    logic [4:0]         coeff_index;
    logic signed [15:0] basis_value;
    logic               last;
  } shbe_out_t;

  // direction plus the band limit that was in force when it was taken
  typedef struct packed {
    shbe_in_t          dir;
    logic [BandW-1:0]  band;
  } shbe_job_t;

  // clamp a 64-bit value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    begin
      hi = 64'sd2147483647;
      lo = -64'sd2147483648;
      if (v > hi) sat32 = 32'sh7fffffff;
      else if (v < lo) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
    end
  endfunction

  // l*(l+1)+m -> band
  function automatic logic [BandW-1:0] idx_band(input logic [IdxW-1:0] i);
    begin
      if (i == 5'd0) idx_band = 3'd0;
      else if (i < 5'd4) idx_band = 3'd1;
      else if (i < 5'd9) idx_band = 3'd2;
      else if (i < 5'd16) idx_band = 3'd3;
      else idx_band = 3'd4;
    end
  endfunction

  // per-index scale constant in millionths
  function automatic logic signed [22:0] idx_k(input logic [IdxW-1:0] i);
    begin
      case (i)
        5'd0:  idx_k = 23'sd282095;
        5'd1:  idx_k = -23'sd488603;
        5'd2:  idx_k = 23'sd488603;
        5'd3:  idx_k = -23'sd488603;
        5'd4:  idx_k = 23'sd1092548;
        5'd5:  idx_k = -23'sd1092548;
        5'd6:  idx_k = 23'sd315392;
        5'd7:  idx_k = -23'sd1092548;
        5'd8:  idx_k = 23'sd546274;
        5'd9:  idx_k = -23'sd590044;
        5'd10: idx_k = 23'sd2890611;
        5'd11: idx_k = -23'sd457046;
        5'd12: idx_k = 23'sd373176;
        5'd13: idx_k = -23'sd457046;
        5'd14: idx_k = 23'sd1445306;
        5'd15: idx_k = -23'sd590044;
        5'd16: idx_k = 23'sd2503343;
        5'd17: idx_k = -23'sd1770131;
        5'd18: idx_k = 23'sd946175;
        5'd19: idx_k = -23'sd669047;
        5'd20: idx_k = 23'sd105786;
        5'd21: idx_k = -23'sd669047;
        5'd22: idx_k = 23'sd473087;
        5'd23: idx_k = -23'sd1770131;
        5'd24: idx_k = 23'sd625836;
        default: idx_k = 23'sd0;
      endcase
    end
  endfunction

endpackage
`default_nettype wire

// ===== sv/shbe_front.sv =====
// front end: takes directions, tags them with the clamped band limit, queues them
`timescale 1ns / 1ps
`default_nettype none
module shbe_front #(
  parameter int unsigned MAX_BAND_LIMIT = shbe_pkg::MaxBandLimit,
  parameter int unsigned DEPTH          = 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire shbe_pkg::shbe_in_t  in_data_i,
  input  wire logic [2:0]          max_band_i,
  output logic                     job_valid_o,
  input  wire logic                job_take_i,
  output shbe_pkg::shbe_job_t      job_o
);
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [2:0] LimW = 3'(MAX_BAND_LIMIT);

  shbe_pkg::shbe_job_t fifo_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic push, pop;
  shbe_pkg::shbe_job_t job_new;

  assign in_stall_o  = (cnt_q == (PtrW+1)'(DEPTH));
  assign push        = in_valid_i && !in_stall_o;
  assign job_valid_o = (cnt_q != '0);
  assign pop         = job_valid_o && job_take_i;
  assign job_o       = fifo_q[rd_q];

  always_comb begin
    job_new.dir  = in_data_i;
    job_new.band = (max_band_i > LimW) ? LimW : max_band_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == PtrW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == PtrW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= job_new;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(DEPTH)) else $error("queue overflow");
  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == (PtrW+1)'(DEPTH)) |-> in_stall_o) else $error("full queue not stalling");
  a_band_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o |-> job_o.band <= LimW) else $error("band above limit");
`endif
endmodule
`default_nettype wire

// ===== sv/shbe_back.sv =====
// back end: monomial stage, polynomial stage, scaling stage, reciprocal divide and output register
`timescale 1ns / 1ps
`default_nettype none
module shbe_back #(
  parameter int unsigned FRAC_BITS = shbe_pkg::FracBits
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 job_valid_i,
  output logic                      job_take_o,
  input  wire shbe_pkg::shbe_job_t  job_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output shbe_pkg::shbe_out_t       out_data_o
);
  localparam logic signed [63:0] One  = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] Half = 64'sd1 <<< (FRAC_BITS - 1);

  // rounded fixed-point product, clamped to 32 bits
  function automatic logic signed [31:0] fmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    begin
      p = 64'(a) * 64'(b) + Half;
      fmul = shbe_pkg::sat32(p >>> FRAC_BITS);
    end
  endfunction

  // ---------------- stage 0: sequencer over coefficients
  logic            seq_busy_q;
  logic [4:0]      idx_q;
  logic [2:0]      band_q;
  shbe_pkg::shbe_in_t dir_q;
  logic            adv;
  logic            s1_ready, s2_ready, s3_ready;
  logic [4:0]      last_idx;

  // last index of band b is b*b+2b
  assign last_idx = ({2'b00, band_q} * {2'b00, band_q}) + {1'b0, band_q, 1'b0};
  assign adv        = seq_busy_q && s1_ready;
  assign job_take_o = job_valid_i && (!seq_busy_q || (adv && idx_q == last_idx));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_busy_q <= 1'b0;
      idx_q      <= '0;
      band_q     <= '0;
    end else if (job_take_o) begin
      seq_busy_q <= 1'b1;
      idx_q      <= '0;
      band_q     <= job_i.band;
    end else if (adv) begin
      if (idx_q == last_idx) seq_busy_q <= 1'b0;
      else idx_q <= idx_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_take_o) dir_q <= job_i.dir;
  end

  // ---------------- stage 1: second-order monomials
  logic        s1_v_q;
  logic [4:0]  s1_idx_q;
  logic        s1_last_q;
  logic signed [31:0] s1_x_q, s1_y_q, s1_z_q, s1_x2_q, s1_y2_q, s1_z2_q;
  logic signed [31:0] s1_xy_q, s1_yz_q, s1_xz_q;

  assign s1_ready = !s1_v_q || s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (s1_ready) s1_v_q <= adv;
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && adv) begin
      s1_idx_q  <= idx_q;
      s1_last_q <= (idx_q == last_idx);
      s1_x_q  <= 32'(dir_q.dir_x);
      s1_y_q  <= 32'(dir_q.dir_y);
      s1_z_q  <= 32'(dir_q.dir_z);
      s1_x2_q <= fmul(32'(dir_q.dir_x), 32'(dir_q.dir_x));
      s1_y2_q <= fmul(32'(dir_q.dir_y), 32'(dir_q.dir_y));
      s1_z2_q <= fmul(32'(dir_q.dir_z), 32'(dir_q.dir_z));
      s1_xy_q <= fmul(32'(dir_q.dir_x), 32'(dir_q.dir_y));
      s1_yz_q <= fmul(32'(dir_q.dir_y), 32'(dir_q.dir_z));
      s1_xz_q <= fmul(32'(dir_q.dir_x), 32'(dir_q.dir_z));
    end
  end

  // ---------------- stage 2: pick one factor pair (and derived combos)
  logic signed [63:0] x2e, y2e, z2e;
  logic signed [31:0] dxy, a3, b3, c3, s7a, s7b, p12, p6, z4;
  logic signed [31:0] fa, fb, fdirect;
  logic               use_mul;
  logic               s2_v_q, s2_last_q, s2_mul_q;
  logic [4:0]         s2_idx_q;
  logic signed [31:0] s2_a_q, s2_b_q, s2_d_q;
  // second pair, for the highest-order term (x2*b3 - y2*a3)
  logic signed [31:0] s2_c_q, s2_e_q;

  always_comb begin
    x2e = 64'(s1_x2_q);
    y2e = 64'(s1_y2_q);
    z2e = 64'(s1_z2_q);
    dxy = shbe_pkg::sat32(x2e - y2e);
    a3  = shbe_pkg::sat32(3 * x2e - y2e);
    b3  = shbe_pkg::sat32(x2e - 3 * y2e);
    c3  = shbe_pkg::sat32(4 * z2e - x2e - y2e);
    s7a = shbe_pkg::sat32(7 * z2e - One);
    s7b = shbe_pkg::sat32(7 * z2e - 3 * One);
    p12 = shbe_pkg::sat32(2 * z2e - 3 * x2e - 3 * y2e);
    p6  = shbe_pkg::sat32(2 * z2e - x2e - y2e);
    z4  = '0;
    fa = s1_z2_q; fb = s1_z2_q; fdirect = '0; use_mul = 1'b1;
    case (s1_idx_q)
      5'd0:  begin fdirect = 32'(One); use_mul = 1'b0; end
      5'd1:  begin fdirect = s1_y_q;   use_mul = 1'b0; end
      5'd2:  begin fdirect = s1_z_q;   use_mul = 1'b0; end
      5'd3:  begin fdirect = s1_x_q;   use_mul = 1'b0; end
      5'd4:  begin fdirect = s1_xy_q;  use_mul = 1'b0; end
      5'd5:  begin fdirect = s1_yz_q;  use_mul = 1'b0; end
      5'd6:  begin fdirect = p6;       use_mul = 1'b0; end
      5'd7:  begin fdirect = s1_xz_q;  use_mul = 1'b0; end
      5'd8:  begin fdirect = dxy;      use_mul = 1'b0; end
      5'd9:  begin fa = s1_y_q;  fb = a3;  end
      5'd10: begin fa = s1_xy_q; fb = s1_z_q; end
      5'd11: begin fa = s1_y_q;  fb = c3;  end
      5'd12: begin fa = s1_z_q;  fb = p12; end
      5'd13: begin fa = s1_x_q;  fb = c3;  end
      5'd14: begin fa = s1_z_q;  fb = dxy; end
      5'd15: begin fa = s1_x_q;  fb = b3;  end
      5'd16: begin fa = s1_xy_q; fb = dxy; end
      5'd17: begin fa = s1_yz_q; fb = a3;  end
      5'd18: begin fa = s1_xy_q; fb = s7a; end
      5'd19: begin fa = s1_yz_q; fb = s7b; end
      5'd20: begin fa = s1_z2_q; fb = s1_z2_q; end
      5'd21: begin fa = s1_xz_q; fb = s7b; end
      5'd22: begin fa = dxy;     fb = s7a; end
      5'd23: begin fa = s1_xz_q; fb = b3;  end
      5'd24: begin fa = s1_x2_q; fb = b3;  end
      default: begin fdirect = z4; use_mul = 1'b0; end
    endcase
  end

  assign s2_ready = !s2_v_q || s3_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (s2_ready) s2_v_q <= s1_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_v_q) begin
      s2_idx_q  <= s1_idx_q;
      s2_last_q <= s1_last_q;
      s2_mul_q  <= use_mul;
      s2_a_q    <= fa;
      s2_b_q    <= fb;
      s2_d_q    <= fdirect;
      s2_c_q    <= s1_y2_q;
      s2_e_q    <= (s1_idx_q == 5'd20) ? s1_z2_q : a3;
    end
  end

  // ---------------- stage 3: product and polynomial finish
  logic signed [31:0] prod, prod2, poly;
  logic signed [63:0] p64;
  logic               s3_v_q, s3_last_q;
  logic [4:0]         s3_idx_q;
  logic signed [31:0] s3_poly_q;

  always_comb begin
    prod  = fmul(s2_a_q, s2_b_q);
    prod2 = fmul(s2_c_q, s2_e_q);
    p64   = '0;
    if (!s2_mul_q) poly = s2_d_q;
    else if (s2_idx_q == 5'd20) begin
      // 35 z^4 - 30 z^2 + 3
      p64  = 35 * 64'(prod) - 30 * 64'(s2_e_q) + 3 * One;
      poly = shbe_pkg::sat32(p64);
    end else if (s2_idx_q == 5'd24) begin
      p64  = 64'(prod) - 64'(prod2);
      poly = shbe_pkg::sat32(p64);
    end else poly = prod;
  end

  logic s4_ready;
  assign s3_ready = !s3_v_q || s4_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else if (s3_ready) s3_v_q <= s2_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_v_q) begin
      s3_idx_q  <= s2_idx_q;
      s3_last_q <= s2_last_q;
      s3_poly_q <= poly;
    end
  end

  // ---------------- stage 4: scale by constant, range check against the 16-bit limits
  // 32768 * 10^6, the scaled value where the output saturates
  localparam logic signed [63:0] SatLim = 64'sd32768000000;
  // floor(m / 15625) == (m * RecipK) >> 44 for every m below 2^30
  localparam logic [31:0] RecipK = 32'd1125899907;

  logic signed [63:0] q, n;
  logic               s4_v_q, s4_last_q, s4_hi_q, s4_lo_q;
  logic [4:0]         s4_idx_q;
  logic [29:0]        s4_m_q;
  logic               s5_ready;

  always_comb begin
    q = 64'(s3_poly_q) * 64'(shbe_pkg::idx_k(s3_idx_q)) + 64'sd500000;
    // offset into 0 .. 65536e6 so the divide is unsigned
    n = q + SatLim;
  end

  assign s4_ready = !s4_v_q || s5_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_v_q <= 1'b0;
    else if (s4_ready) s4_v_q <= s3_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (s4_ready && s3_v_q) begin
      s4_idx_q  <= s3_idx_q;
      s4_last_q <= s3_last_q;
      s4_hi_q   <= (q >= SatLim);
      s4_lo_q   <= (q < -SatLim);
      // 10^6 = 64 * 15625, the low six bits drop out first
      s4_m_q    <= n[35:6];
    end
  end

  // ---------------- stage 5: divide by 15625, saturate, output register
  logic [61:0]        quo;
  logic signed [15:0] v16;
  logic [2:0]         l_w;
  logic [4:0]         base;
  logic               o_v_q;
  shbe_pkg::shbe_out_t o_q;

  always_comb begin
    quo = 62'(s4_m_q) * 62'(RecipK);
    // quotient is 0..65535, removing the 32768 offset flips its top bit
    if (s4_hi_q) v16 = 16'sh7fff;
    else if (s4_lo_q) v16 = 16'sh8000;
    else v16 = {~quo[59], quo[58:44]};
    l_w  = shbe_pkg::idx_band(s4_idx_q);
    base = ({2'b00, l_w} * {2'b00, l_w}) + {2'b00, l_w};
  end

  assign s5_ready = !o_v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) o_v_q <= 1'b0;
    else if (s5_ready) o_v_q <= s4_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (s5_ready && s4_v_q) begin
      o_q.band_l      <= l_w;
      o_q.order_m     <= 4'(s4_idx_q - base);
      o_q.coeff_index <= s4_idx_q;
      o_q.basis_value <= v16;
      o_q.last        <= s4_last_q;
    end
  end

  assign out_valid_o = o_v_q;
  assign out_data_o  = o_q;

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_busy_q |-> idx_q <= last_idx) else $error("index past band");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_v_q && out_stall_i) |=> (o_v_q && $stable(o_q))) else $error("output lost");
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_take_o |-> job_valid_i) else $error("take without job");
`endif
endmodule
`default_nettype wire

// ===== sv/sh_basis_evaluator.sv =====
// Throughput: (b+1)^2 results per direction, b being max_band clamped to
// MAX_BAND_LIMIT, one per cycle while out_stall_i is low; the coefficient
// sequencer in the back end sets this, and a queued direction starts right
// after the previous one's last index, with no gap.
// Reset: asynchronous active low; clears all valid flags and queue
// pointers and sets max_band to 2.
`timescale 1ns / 1ps
`default_nettype none
module sh_basis_evaluator #(
  parameter int unsigned MAX_BAND_LIMIT = shbe_pkg::MaxBandLimit,
  parameter int unsigned FRAC_BITS      = shbe_pkg::FracBits
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire shbe_pkg::shbe_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output shbe_pkg::shbe_out_t      out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [2:0]          cfg_data_i
);
  logic [2:0] max_band_q;
  logic job_valid, job_take;
  shbe_pkg::shbe_job_t job;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) max_band_q <= shbe_pkg::MaxBandReset;
    else if (cfg_valid_i && cfg_ready_o) max_band_q <= cfg_data_i;
  end

  shbe_front #(.MAX_BAND_LIMIT(MAX_BAND_LIMIT)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .in_data_i,
    .max_band_i (max_band_q),
    .job_valid_o(job_valid), .job_take_i(job_take), .job_o(job)
  );

  shbe_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i(job_valid), .job_take_o(job_take), .job_i(job),
    .out_valid_o, .out_stall_i, .out_data_o
  );
endmodule
`default_nettype wire
